FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/fgem_pkg.sv
// Package for the flow gradient edge mask: sizes, register codes, queue entry type.
// No dependencies; used by every design module of the block.
`default_nettype none

package fgem_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned CW         = DIM_W + 1;
  localparam int unsigned FLOW_W     = 16;
  localparam int unsigned PIX_W      = 2 * FLOW_W;
  localparam int unsigned DIFF_W     = FLOW_W + 1;
  localparam int unsigned SQ_W       = 2 * FLOW_W;
  localparam int unsigned SUM_W      = SQ_W + 2;
  localparam int unsigned THR_W      = 36;
  localparam int unsigned CFG_DATA_W = 36;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD_SQ = 2'd2
  } cfg_idx_e;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } fgem_dims_t;

  // One queue entry holds the results of one beat: the center column to
  // the left, and at row end also the last column (no horizontal term).
  typedef struct packed {
    logic  two;
    logic  eof;
    diff_t hx;
    diff_t hy;
    diff_t vx;
    diff_t vy;
    diff_t vx2;
    diff_t vy2;
  } fgem_entry_t;

  function automatic diff_t fdiff(input logic [FLOW_W-1:0] hi, input logic [FLOW_W-1:0] lo);
    diff_t r;
    r = $signed({hi[FLOW_W-1], hi}) - $signed({lo[FLOW_W-1], lo});
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/flow_gradient_edge_mask.sv
// Top level of the flow gradient edge mask: configuration registers and the
// front end, queue and back end. Depends on fgem_pkg, fgem_front, fgem_queue, fgem_back.
//
//   channel | signals                          | beat
//   --------+----------------------------------+------------------------------
//   input   | in_valid_i/in_ready_o            | flow_x_i, flow_y_i (one pixel)
//   output  | out_valid_o/out_ready_i          | is_smooth_o, end_of_frame_o,
//           |                                  | end_of_run_o (one result)
//   config  | cfg_we_i                         | cfg_idx_i, cfg_data_i
//
// One pixel per cycle sustained while the output is not stalled; the back end squares
// and sums at one result per cycle, so the extra result at each row end is absorbed by
// the 4-entry queue. A pixel beat reaches its result beat through the read stage,
// queue, square, sum and compare. Results of a row follow one row behind the input.
// No clearing pass after reset: the row store needs no initial contents.
// Each side stalls on its own; the input stalls only once the queue is full.
`default_nettype none

module flow_gradient_edge_mask (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fgem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fgem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [fgem_pkg::FLOW_W-1:0]     flow_x_i,
  input  wire logic [fgem_pkg::FLOW_W-1:0]     flow_y_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 is_smooth_o,
  output logic                                 end_of_frame_o,
  output logic                                 end_of_run_o
);
  import fgem_pkg::*;

  fgem_dims_t        dims_q;
  logic [THR_W-1:0]  thr_q;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  fgem_entry_t       push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q.frame_width  <= DIM_W'(640);
      dims_q.frame_height <= DIM_W'(480);
      thr_q               <= THR_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  dims_q.frame_width  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: dims_q.frame_height <= cfg_data_i[DIM_W-1:0];
        CFG_THRESHOLD_SQ: thr_q               <= cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fgem_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dims_i     (dims_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flow_x_i   (flow_x_i),
    .flow_y_i   (flow_y_i),
    .q_valid_o  (push_valid),
    .q_ready_i  (push_ready),
    .q_data_o   (push_data)
  );

  fgem_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  fgem_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (pop_valid),
    .q_ready_o      (pop_ready),
    .q_data_i       (pop_data),
    .thr_i          (thr_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .is_smooth_o    (is_smooth_o),
    .end_of_frame_o (end_of_frame_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule

`default_nettype wire

FILE: hdl/fgem_front.sv
// Front end: accepts pixels, keeps the raster counters and the two-row store,
// and forms the derivative operands of each result. Depends on fgem_pkg.
`default_nettype none

module fgem_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire fgem_pkg::fgem_dims_t      dims_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [fgem_pkg::FLOW_W-1:0] flow_x_i,
  input  wire logic [fgem_pkg::FLOW_W-1:0] flow_y_i,
  output logic                           q_valid_o,
  input  wire logic                      q_ready_i,
  output fgem_pkg::fgem_entry_t          q_data_o
);
  import fgem_pkg::*;

  // row store word: {older row, newer row}
  logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];

  logic [ADDR_W-1:0] cc_q, cc_d;
  logic [DIM_W-1:0]  rc_q, rc_d;
  logic              fp_q, fp_d;

  logic [CW-1:0]     w, x, cc_w, x_inc;
  logic [DIM_W-1:0]  h, y;
  logic              last_col, last_row, flush, emit;
  logic [ADDR_W-1:0] addr, addr_l;
  logic              accept;

  logic              s1_v_q;
  logic [ADDR_W-1:0] s1_x_q;
  logic [PIX_W-1:0]  s1_p_q, s1_fpix_q;
  logic              s1_emit_q, s1_two_q, s1_eof_q, s1_vz_q, s1_c0_q, s1_fwd_q;
  logic [2*PIX_W-1:0] rd_q, rd2_q;
  logic [PIX_W-1:0]  pw0_q, pw1_q, pw2_q;

  logic              s1_go;
  logic [PIX_W-1:0]  a, b, down, left, up, dn, up2, dn2;

  always_comb begin
    if (dims_i.frame_width < DIM_W'(2)) begin
      w = CW'(2);
    end else if ({1'b0, dims_i.frame_width} > CW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = {1'b0, dims_i.frame_width};
    end
    h = (dims_i.frame_height < DIM_W'(2)) ? DIM_W'(2) : dims_i.frame_height;
    // counters beyond a shrunken size count as the last column / row
    cc_w     = CW'(cc_q);
    x        = (cc_w >= w) ? (w - CW'(1)) : cc_w;
    y        = (rc_q >= h) ? (h - DIM_W'(1)) : rc_q;
    last_col = (x == (w - CW'(1)));
    last_row = (y == (h - DIM_W'(1)));
    flush    = (y == '0) && fp_q;
    emit     = (flush || (y != '0)) && (x != '0);
    addr     = x[ADDR_W-1:0];
    addr_l   = addr - ADDR_W'(1);
    x_inc    = x + CW'(1);
  end

  always_comb begin
    cc_d = cc_q;
    rc_d = rc_q;
    fp_d = fp_q;
    if (accept) begin
      if (last_col) begin
        cc_d = '0;
        if (y == '0) begin
          fp_d = 1'b0;
        end
        if (last_row) begin
          rc_d = '0;
          fp_d = 1'b1;
        end else begin
          rc_d = y + DIM_W'(1);
        end
      end else begin
        cc_d = x_inc[ADDR_W-1:0];
        rc_d = y;
      end
    end
  end

  assign s1_go      = s1_v_q && (!s1_emit_q || q_ready_i);
  assign in_ready_o = !s1_v_q || s1_go;
  assign accept     = in_valid_i && in_ready_o;
  assign q_valid_o  = s1_v_q && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      rc_q   <= '0;
      fp_q   <= 1'b0;
      s1_v_q <= 1'b0;
      pw0_q  <= '0;
      pw1_q  <= '0;
      pw2_q  <= '0;
    end else begin
      cc_q <= cc_d;
      rc_q <= rc_d;
      fp_q <= fp_d;
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (s1_go) begin
        pw2_q <= pw1_q;
        pw1_q <= b;
        pw0_q <= a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q    <= addr;
      s1_p_q    <= {flow_y_i, flow_x_i};
      s1_emit_q <= emit;
      s1_two_q  <= emit && last_col;
      s1_eof_q  <= flush;
      s1_vz_q   <= flush || (y == DIM_W'(1));
      s1_c0_q   <= (x == CW'(1));
      // the beat ahead has not written its column yet
      s1_fwd_q  <= s1_v_q && (s1_x_q == addr_l);
      s1_fpix_q <= s1_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      row_mem[s1_x_q] <= {b, s1_p_q};
    end
    if (accept) begin
      rd_q  <= row_mem[addr];
      rd2_q <= row_mem[addr_l];
    end
  end

  always_comb begin
    a    = rd_q[2*PIX_W-1:PIX_W];
    b    = rd_q[PIX_W-1:0];
    down = s1_fwd_q ? s1_fpix_q : rd2_q[PIX_W-1:0];
    left = s1_c0_q ? b : pw2_q;
    up   = s1_vz_q ? '0 : pw0_q;
    dn   = s1_vz_q ? '0 : down;
    up2  = s1_vz_q ? '0 : a;
    dn2  = s1_vz_q ? '0 : s1_p_q;

    q_data_o.two = s1_two_q;
    q_data_o.eof = s1_eof_q;
    q_data_o.hx  = fdiff(b[FLOW_W-1:0], left[FLOW_W-1:0]);
    q_data_o.hy  = fdiff(b[PIX_W-1:FLOW_W], left[PIX_W-1:FLOW_W]);
    q_data_o.vx  = fdiff(dn[FLOW_W-1:0], up[FLOW_W-1:0]);
    q_data_o.vy  = fdiff(dn[PIX_W-1:FLOW_W], up[PIX_W-1:FLOW_W]);
    q_data_o.vx2 = fdiff(dn2[FLOW_W-1:0], up2[FLOW_W-1:0]);
    q_data_o.vy2 = fdiff(dn2[PIX_W-1:FLOW_W], up2[PIX_W-1:FLOW_W]);
  end

endmodule

`default_nettype wire

FILE: hdl/fgem_queue.sv
// Short queue between the front and back ends, in flops.
// Depends on fgem_pkg.
`default_nettype none

module fgem_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_valid_i,
  output logic                       push_ready_o,
  input  wire fgem_pkg::fgem_entry_t push_data_i,
  output logic                       pop_valid_o,
  input  wire logic                  pop_ready_i,
  output fgem_pkg::fgem_entry_t      pop_data_o
);
  import fgem_pkg::*;

  fgem_entry_t        slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_q, rp_q;
  logic [Q_PTR_W:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != (Q_PTR_W+1)'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + Q_PTR_W'(1);
      end
      if (pop) begin
        rp_q <= rp_q + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fgem_back.sv
// Back end: squares the derivatives, sums them, compares with the threshold
// and holds the result beat. Depends on fgem_pkg.
`default_nettype none

module fgem_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  output logic                          q_ready_o,
  input  wire fgem_pkg::fgem_entry_t    q_data_i,
  input  wire logic [fgem_pkg::THR_W-1:0] thr_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          is_smooth_o,
  output logic                          end_of_frame_o,
  output logic                          end_of_run_o
);
  import fgem_pkg::*;

  logic              sub_q;
  logic              a_v_q, b_v_q, c_v_q;
  logic [SQ_W-1:0]   a_sq_q [4];
  logic              a_eof_q, a_eor_q, b_eof_q, b_eor_q, c_eof_q, c_eor_q;
  logic [SUM_W-1:0]  b_sum_q;
  logic              c_smooth_q;

  logic              c_rdy, b_rdy, a_rdy, take, last;
  diff_t             d [4];
  logic signed [2*DIFF_W-1:0] prod [4];

  assign c_rdy     = !c_v_q || out_ready_i;
  assign b_rdy     = !b_v_q || c_rdy;
  assign a_rdy     = !a_v_q || b_rdy;
  assign take      = q_valid_i && a_rdy;
  // second pass of a row-end entry, or a single-result entry
  assign last      = sub_q || !q_data_i.two;
  assign q_ready_o = a_rdy && last;

  always_comb begin
    if (sub_q) begin
      d[0] = '0;
      d[1] = '0;
      d[2] = q_data_i.vx2;
      d[3] = q_data_i.vy2;
    end else begin
      d[0] = q_data_i.hx;
      d[1] = q_data_i.hy;
      d[2] = q_data_i.vx;
      d[3] = q_data_i.vy;
    end
    for (int i = 0; i < 4; i++) begin
      prod[i] = d[i] * d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (take) begin
        sub_q <= !last;
      end
      if (a_rdy) begin
        a_v_q <= q_valid_i;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
      if (c_rdy) begin
        c_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < 4; i++) begin
        a_sq_q[i] <= prod[i][SQ_W-1:0];
      end
      a_eof_q <= sub_q && q_data_i.eof;
      a_eor_q <= last;
    end
    if (a_v_q && b_rdy) begin
      b_sum_q <= SUM_W'(a_sq_q[0]) + SUM_W'(a_sq_q[1])
               + SUM_W'(a_sq_q[2]) + SUM_W'(a_sq_q[3]);
      b_eof_q <= a_eof_q;
      b_eor_q <= a_eor_q;
    end
    if (b_v_q && c_rdy) begin
      c_smooth_q <= (THR_W'(b_sum_q) <= thr_i);
      c_eof_q    <= b_eof_q;
      c_eor_q    <= b_eor_q;
    end
  end

  assign out_valid_o    = c_v_q;
  assign is_smooth_o    = c_smooth_q;
  assign end_of_frame_o = c_eof_q;
  assign end_of_run_o   = c_eor_q;

endmodule

`default_nettype wire

FILE: hdl/fgem_checker.sv
// Port-level checks of the flow gradient edge mask, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fgem_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic is_smooth_o,
  input wire logic end_of_frame_o,
  input wire logic end_of_run_o
);

  logic       out_stall;
  logic [2:0] out_beat;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_beat  = {is_smooth_o, end_of_frame_o, end_of_run_o};

  // a stalled result beat stays
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o, "beat dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(out_beat), "beat changed in stall")
  // the frame's last result closes the run of its pixel
  `ASSERT_CLK(a_eof_eor, clk_i, rst_ni, out_valid_o && end_of_frame_o |-> end_of_run_o, "eof, no eor")
  // reset clears the output stage
  `ASSERT_ANY(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "result beat after reset edge")

endmodule

bind flow_gradient_edge_mask fgem_checker u_fgem_checker (.*);

`default_nettype wire
